// ===== src/imaenc_pkg.sv =====
// Shared types, constants and tables for the stereo IMA ADPCM encoder.
// Holds the step-size table, the index adjust function and controller types.
// Depends on nothing; the lane, controller, encoder and testbench import it.
package imaenc_pkg;

	localparam logic [6:0] IDX_MAX  = 7'd88;
	localparam logic [2:0] CODE_MAX = 3'd7;
	localparam logic signed [17:0] PRED_MAX = 18'sd32767;
	localparam logic signed [17:0] PRED_MIN = -18'sd32768;

	localparam logic [14:0] STEP_TAB [0:88] = '{
		15'd7,     15'd8,     15'd9,     15'd10,    15'd11,    15'd12,    15'd13,
		15'd14,    15'd16,    15'd17,    15'd19,    15'd21,    15'd23,    15'd25,
		15'd28,    15'd31,    15'd34,    15'd37,    15'd41,    15'd45,    15'd50,
		15'd55,    15'd60,    15'd66,    15'd73,    15'd80,    15'd88,    15'd97,
		15'd107,   15'd118,   15'd130,   15'd143,   15'd157,   15'd173,   15'd190,
		15'd209,   15'd230,   15'd253,   15'd279,   15'd307,   15'd337,   15'd371,
		15'd408,   15'd449,   15'd494,   15'd544,   15'd598,   15'd658,   15'd724,
		15'd796,   15'd876,   15'd963,   15'd1060,  15'd1166,  15'd1282,  15'd1411,
		15'd1552,  15'd1707,  15'd1878,  15'd2066,  15'd2272,  15'd2499,  15'd2749,
		15'd3024,  15'd3327,  15'd3660,  15'd4026,  15'd4428,  15'd4871,  15'd5358,
		15'd5894,  15'd6484,  15'd7132,  15'd7845,  15'd8630,  15'd9493,  15'd10442,
		15'd11487, 15'd12635, 15'd13899, 15'd15289, 15'd16818, 15'd18500, 15'd20350,
		15'd22385, 15'd24623, 15'd27086, 15'd29794, 15'd32767
	};

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_DIVIDE,
		ST_UPDATE
	} imaenc_state_t;

	typedef struct packed {
		logic       load;
		logic       div;
		logic [1:0] shift;
		logic       update;
	} imaenc_cmd_t;

	function automatic logic signed [4:0] adj_of(input logic [2:0] code);
		logic signed [4:0] adj;
		case (code)
			3'd0, 3'd1, 3'd2, 3'd3: adj = -5'sd1;
			3'd4: adj = 5'sd2;
			3'd5: adj = 5'sd4;
			3'd6: adj = 5'sd6;
			3'd7: adj = 5'sd8;
			default: adj = -5'sd1;
		endcase
		return adj;
	endfunction

endpackage

// ===== src/imaenc_frame_if.sv =====
// Handshake interface that carries one stereo PCM frame as a word.
// Depends on nothing.
interface imaenc_frame_if;
	logic               valid;
	logic               ready;
	logic signed [15:0] left_sample;
	logic signed [15:0] right_sample;

	modport source(output valid, output left_sample, output right_sample, input ready);
	modport sink(input valid, input left_sample, input right_sample, output ready);
endinterface

// ===== src/imaenc_codes_if.sv =====
// Handshake interface that carries one packed byte of two ADPCM nibbles as a word.
// Depends on nothing.
interface imaenc_codes_if;
	logic       valid;
	logic       ready;
	logic [7:0] packed_codes;

	modport source(output valid, output packed_codes, input ready);
	modport sink(input valid, input packed_codes, output ready);
endinterface

// ===== src/imaenc_lane.sv =====
// Datapath for one audio channel: predictor, step index, iterative quotient.
// Depends on imaenc_pkg for the step table, adjust function and command type.
module imaenc_lane (
	input  logic                      clk,
	input  logic                      arst_n,
	input  imaenc_pkg::imaenc_cmd_t   cmd,
	input  logic signed [15:0]        sample,
	output logic [3:0]                nibble
);
	import imaenc_pkg::*;

	logic signed [15:0] pred_q;
	logic [6:0]         idx_q;
	logic [17:0]        rem_q;
	logic [14:0]        step_q;
	logic [3:0]         quo_q;
	logic               neg_q;

	logic [16:0]        diff;
	logic [16:0]        mag;
	logic [17:0]        trial;
	logic [2:0]         code;
	logic [17:0]        prod;
	logic [16:0]        delta;
	logic signed [17:0] psum;
	logic signed [15:0] pred_next;
	logic signed [8:0]  isum;
	logic [6:0]         idx_next;
	logic signed [4:0]  adj;

	always_comb begin
		diff  = {sample[15], sample} - {pred_q[15], pred_q};
		mag   = diff[16] ? (~diff + 17'd1) : diff;
		trial = {3'b000, step_q} << cmd.shift;
		code  = quo_q[3] ? CODE_MAX : quo_q[2:0];
		prod  = 18'(step_q) * 18'(code);
		delta = {1'b0, prod[17:2]} + {5'b00000, step_q[14:3]};
		if (neg_q) begin
			psum = $signed({pred_q[15], pred_q[15], pred_q}) - $signed({1'b0, delta});
		end else begin
			psum = $signed({pred_q[15], pred_q[15], pred_q}) + $signed({1'b0, delta});
		end
		if (psum > PRED_MAX) begin
			pred_next = PRED_MAX[15:0];
		end else if (psum < PRED_MIN) begin
			pred_next = PRED_MIN[15:0];
		end else begin
			pred_next = psum[15:0];
		end
		adj  = adj_of(code);
		isum = $signed({2'b00, idx_q}) + $signed({{4{adj[4]}}, adj});
		if (isum[8]) begin
			idx_next = 7'd0;
		end else if (isum > $signed({2'b00, IDX_MAX})) begin
			idx_next = IDX_MAX;
		end else begin
			idx_next = isum[6:0];
		end
		nibble = {neg_q, code};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pred_q <= '0;
			idx_q  <= '0;
		end else if (cmd.update) begin
			pred_q <= pred_next;
			idx_q  <= idx_next;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			neg_q  <= diff[16];
			rem_q  <= {mag[15:0], 2'b00};
			step_q <= STEP_TAB[idx_q];
			quo_q  <= '0;
		end else if (cmd.div) begin
			if (rem_q >= trial) begin
				rem_q            <= rem_q - trial;
				quo_q[cmd.shift] <= 1'b1;
			end
		end
	end

	a_idx_range: assert property (@(posedge clk) disable iff (!arst_n) idx_q <= IDX_MAX)
		else $error("Step index left its range.");

endmodule

// ===== src/imaenc_ctrl.sv =====
// Controller state machine that sequences load, four quotient steps and update.
// Owns the output valid flag. Depends on imaenc_pkg for the state and command types.
module imaenc_ctrl (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    in_valid,
	output logic                    in_ready,
	output logic                    out_valid,
	input  logic                    out_ready,
	output imaenc_pkg::imaenc_cmd_t cmd
);
	import imaenc_pkg::*;

	imaenc_state_t state_q, state_next;
	logic [1:0]    cnt_q;
	logic          out_valid_q;

	always_comb begin
		state_next = state_q;
		case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					state_next = ST_DIVIDE;
				end
			end
			ST_DIVIDE: begin
				if (cnt_q == 2'd0) begin
					state_next = ST_UPDATE;
				end
			end
			ST_UPDATE: begin
				if (!out_valid_q || out_ready) begin
					state_next = ST_IDLE;
				end
			end
			default: state_next = ST_IDLE;
		endcase
	end

	always_comb begin
		in_ready   = 1'b0;
		cmd        = '0;
		cmd.shift  = cnt_q;
		case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				cmd.load = in_valid;
			end
			ST_DIVIDE: begin
				cmd.div = 1'b1;
			end
			ST_UPDATE: begin
				cmd.update = !out_valid_q || out_ready;
			end
			default: begin
				in_ready = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			cnt_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_next;
			if (cmd.load) begin
				cnt_q <= 2'd3;
			end else if (cmd.div) begin
				cnt_q <= cnt_q - 2'd1;
			end
			if (cmd.update) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign out_valid = out_valid_q;

	a_load_then_div: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> cmd.div && cnt_q == 2'd3)
		else $error("Quotient steps did not start after a frame was taken.");

	a_update_sets_valid: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.update |=> out_valid_q)
		else $error("Update did not present a result.");

	a_valid_from_update: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(cmd.update))
		else $error("Result appeared without an update.");

	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.update |-> !out_valid_q || out_ready)
		else $error("Update would overwrite a pending result.");

endmodule

// ===== src/ima_adpcm_stereo_encoder.sv =====
// Stereo IMA ADPCM encoder: one frame of two 16-bit samples in, one byte out.
// Depends on imaenc_pkg, imaenc_frame_if, imaenc_codes_if, imaenc_lane and imaenc_ctrl.
//
// The frame channel takes a word holding a left and a right signed sample. The
// codes channel returns one byte per frame: the left nibble in bits 7:4 and the
// right nibble in bits 3:0, each with the sign in bit 3 and the magnitude below.
// Both channels are encoded side by side in two identical lanes.
// A frame is taken when frame.valid and frame.ready are high at a clock edge.
// Each frame passes through a load of the difference, four quotient steps
// of a shared compare-and-subtract per lane, and an update of predictor and
// index. The byte is valid in the cycle after the update. A new frame is
// taken only once the block has returned to idle after the update.
// The result sits in an output register; a new frame is accepted while it waits.
// If the receiver stalls, the block finishes the next frame and holds it in the
// update step until the waiting byte has been taken.
// Reset clears both predictors and step indices to zero and empties the output.
module ima_adpcm_stereo_encoder (
	input logic            clk,
	input logic            arst_n,
	imaenc_frame_if.sink   frame,
	imaenc_codes_if.source codes
);
	import imaenc_pkg::*;

	imaenc_cmd_t cmd;
	logic [3:0]  left_nibble;
	logic [3:0]  right_nibble;
	logic [7:0]  codes_q;

	imaenc_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (frame.valid),
		.in_ready  (frame.ready),
		.out_valid (codes.valid),
		.out_ready (codes.ready),
		.cmd       (cmd)
	);

	imaenc_lane u_left (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (cmd),
		.sample (frame.left_sample),
		.nibble (left_nibble)
	);

	imaenc_lane u_right (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (cmd),
		.sample (frame.right_sample),
		.nibble (right_nibble)
	);

	always_ff @(posedge clk) begin
		if (cmd.update) begin
			codes_q <= {left_nibble, right_nibble};
		end
	end

	assign codes.packed_codes = codes_q;

endmodule

// ===== dv/tb_ima_adpcm_stereo_encoder.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for the stereo IMA ADPCM encoder: a directed table of frames,
// then random frames, each byte checked against a table value or a per-lane model.
// Depends on imaenc_pkg, imaenc_frame_if, imaenc_codes_if and ima_adpcm_stereo_encoder.
module tb_ima_adpcm_stereo_encoder;
	import imaenc_pkg::*;

	localparam int CYCLE_LIMIT = 200000;
	localparam int RANDOM_FRAMES = 630;
	localparam int DRAIN_CYCLES = 20;
	localparam int LANE_LEFT = 0;
	localparam int LANE_RIGHT = 1;
	localparam int IDX_ADJUST [0:7] = '{-1, -1, -1, -1, 2, 4, 6, 8};

	typedef struct packed {
		logic signed [15:0] left_s;
		logic signed [15:0] right_s;
		logic               typed;
		logic [7:0]         known;
	} frame_row_t;

	localparam int N_DIRECTED = 22;
	localparam frame_row_t DIRECTED [0:N_DIRECTED-1] = '{
		'{16'sd0, 16'sd0, 1'b1, 8'h00},
		'{16'sd0, 16'sd0, 1'b1, 8'h00},
		'{16'h7FFF, 16'h8000, 1'b1, 8'h7F},
		'{16'h7FFF, 16'h8000, 1'b0, 8'h00},
		'{16'h7FFF, 16'h8000, 1'b0, 8'h00},
		'{16'h7FFF, 16'h8000, 1'b0, 8'h00},
		'{16'h7FFF, 16'h8000, 1'b0, 8'h00},
		'{16'h7FFF, 16'h8000, 1'b0, 8'h00},
		'{16'h7FFF, 16'h8000, 1'b0, 8'h00},
		'{16'h7FFF, 16'h8000, 1'b0, 8'h00},
		'{16'h7FFF, 16'h8000, 1'b0, 8'h00},
		'{16'h7FFF, 16'h8000, 1'b0, 8'h00},
		'{16'h7FFF, 16'h8000, 1'b0, 8'h00},
		'{16'h7FFF, 16'h8000, 1'b0, 8'h00},
		'{16'h8000, 16'h7FFF, 1'b0, 8'h00},
		'{16'h8000, 16'h7FFF, 1'b0, 8'h00},
		'{16'sd0, 16'sd0, 1'b0, 8'h00},
		'{16'sd1000, -16'sd1000, 1'b0, 8'h00},
		'{-16'sd1, 16'sd1, 1'b0, 8'h00},
		'{16'h7FFF, 16'h7FFF, 1'b0, 8'h00},
		'{16'h8000, 16'h8000, 1'b0, 8'h00},
		'{16'sd0, 16'sd0, 1'b0, 8'h00}
	};

	logic clk;
	logic arst_n;

	imaenc_frame_if frame_bus();
	imaenc_codes_if codes_bus();

	ima_adpcm_stereo_encoder u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.frame(frame_bus),
		.codes(codes_bus)
	);

	logic signed [15:0] lane_pred [0:1];
	logic [6:0]         lane_idx [0:1];
	logic [7:0]         expected_codes [$];
	int                 n_errors = 0;
	int                 n_codes = 0;
	int                 cycle_cnt = 0;
	bit                 idle_en = 1'b1;

	initial clk = 1'b0;
	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	function automatic logic [3:0] predict_nibble(input int lane, input logic signed [15:0] sample);
		int step, diff, mag, code, delta, p, ni;
		step = int'(STEP_TAB[(lane_idx[lane] > IDX_MAX) ? IDX_MAX : lane_idx[lane]]);
		diff = int'(sample) - int'(lane_pred[lane]);
		mag = (diff < 0) ? -diff : diff;
		code = (4 * mag) / step;
		if (code > CODE_MAX)
			code = CODE_MAX;
		delta = (step * code) / 4 + step / 8;
		p = (diff < 0) ? int'(lane_pred[lane]) - delta : int'(lane_pred[lane]) + delta;
		if (p > PRED_MAX)
			p = PRED_MAX;
		if (p < PRED_MIN)
			p = PRED_MIN;
		lane_pred[lane] = p[15:0];
		ni = int'(lane_idx[lane]) + IDX_ADJUST[code];
		if (ni < 0)
			ni = 0;
		if (ni > IDX_MAX)
			ni = IDX_MAX;
		lane_idx[lane] = ni[6:0];
		return {diff < 0, code[2:0]};
	endfunction

	task automatic offer_frame(input logic signed [15:0] l, input logic signed [15:0] r,
			input logic typed, input logic [7:0] known);
		logic [7:0] predicted;
		while (idle_en && $urandom_range(0, 99) < 11) begin
			frame_bus.valid <= 1'b0;
			@(negedge clk);
		end
		frame_bus.valid <= 1'b1;
		frame_bus.left_sample <= l;
		frame_bus.right_sample <= r;
		do @(posedge clk); while (!frame_bus.ready);
		predicted = {predict_nibble(LANE_LEFT, l), predict_nibble(LANE_RIGHT, r)};
		expected_codes.push_back(typed ? known : predicted);
		@(negedge clk);
	endtask

	function automatic logic signed [15:0] walk_sample(input logic signed [15:0] prev);
		int step_range, v;
		step_range = 1 << $urandom_range(0, 14);
		v = int'(prev) + $urandom_range(0, 2 * step_range) - step_range;
		if (v > 32767)
			v = 32767;
		if (v < -32768)
			v = -32768;
		return v[15:0];
	endfunction

	initial begin
		logic signed [15:0] l, r;
		int mode;
		arst_n = 1'b0;
		frame_bus.valid = 1'b0;
		frame_bus.left_sample = '0;
		frame_bus.right_sample = '0;
		for (int i = 0; i < 2; i++) begin
			lane_pred[i] = '0;
			lane_idx[i] = '0;
		end
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		for (int i = 0; i < N_DIRECTED; i++)
			offer_frame(DIRECTED[i].left_s, DIRECTED[i].right_s, DIRECTED[i].typed,
				DIRECTED[i].known);

		l = '0;
		r = '0;
		for (int i = 0; i < RANDOM_FRAMES; i++) begin
			idle_en = !(i >= 200 && i < 350);
			mode = $urandom_range(0, 9);
			if (mode < 3) begin
				l = 16'($urandom);
				r = 16'($urandom);
			end else if (mode < 8) begin
				l = walk_sample(l);
				r = walk_sample(r);
			end else if (mode == 8) begin
				l = $urandom_range(0, 1) ? 16'h7FFF : 16'h8000;
				r = $urandom_range(0, 1) ? 16'h7FFF : 16'h8000;
			end
			offer_frame(l, r, 1'b0, 8'h00);
		end
		frame_bus.valid <= 1'b0;
		idle_en = 1'b1;

		while (expected_codes.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (n_errors == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

	// Once, the receiver stops taking words for a long while so that the encoder backs up.
	initial begin
		int  hold_left;
		bit  hold_done;
		hold_left = 0;
		hold_done = 1'b0;
		codes_bus.ready = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_left > 0) begin
				hold_left--;
				codes_bus.ready <= 1'b0;
			end else if (!hold_done && n_codes >= 300) begin
				hold_done = 1'b1;
				hold_left = 150;
				codes_bus.ready <= 1'b0;
			end else begin
				codes_bus.ready <= !(idle_en && $urandom_range(0, 99) < 11);
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n && codes_bus.valid && codes_bus.ready) begin
			n_codes++;
			if (expected_codes.size() == 0) begin
				$error("packed_codes: unexpected word %02h", codes_bus.packed_codes);
				n_errors++;
			end else begin
				if (codes_bus.packed_codes !== expected_codes[0]) begin
					$error("packed_codes: expected %02h, actual %02h", expected_codes[0],
						codes_bus.packed_codes);
					n_errors++;
				end
				void'(expected_codes.pop_front());
			end
		end
	end

	always @(posedge clk) begin
		cycle_cnt++;
		if (cycle_cnt >= CYCLE_LIMIT) begin
			$display("tb: failure");
			$finish;
		end
	end

endmodule

// ===== filelist.f =====
src/imaenc_pkg.sv
src/imaenc_frame_if.sv
src/imaenc_codes_if.sv
src/imaenc_lane.sv
src/imaenc_ctrl.sv
src/ima_adpcm_stereo_encoder.sv
dv/tb_ima_adpcm_stereo_encoder.sv
